// ===== hdl/sos_pkg.sv =====
package sos_pkg;

  localparam int MAX_OBJECTS = 6;
  localparam int ANGLE_MAX   = 180;
  localparam int TAN_SPAN_LIMIT = 180;

  localparam logic [63:0]        PI_Q30  = 64'd3373259426;
  localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

  typedef enum logic {
    REG_NEAR_LIMIT = 1'b0,
    REG_ANGLE_STEP = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic start;
    logic take;
  } arith_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_sts_t;

  typedef logic [255:0][15:0] tan_rom_t;

  // shift-subtract divide, used only while building the tangent table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // tan(span/2 deg) in Q6.10 from Q30 sine and cosine series
  function automatic logic [15:0] tan_q10(input int span);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        den;
    logic [63:0]        q;
    logic signed [63:0] s;
    logic signed [63:0] c;
    if (span >= TAN_SPAN_LIMIT) begin
      return 16'hFFFF;
    end
    x  = udiv64(64'(span) * PI_Q30, 64'd360);
    x2 = (x * x) >> 30;
    s = signed'(x);
    term = x;
    for (int n = 1; n <= 20; n++) begin
      den  = 64'((2 * n) * (2 * n + 1));
      term = udiv64((term * x2) >> 30, den);
      if ((n & 1) != 0) begin
        s = s - signed'(term);
      end else begin
        s = s + signed'(term);
      end
    end
    c = ONE_Q30;
    term = unsigned'(ONE_Q30);
    for (int n = 1; n <= 20; n++) begin
      den  = 64'((2 * n - 1) * (2 * n));
      term = udiv64((term * x2) >> 30, den);
      if ((n & 1) != 0) begin
        c = c - signed'(term);
      end else begin
        c = c + signed'(term);
      end
    end
    if (c <= 0) begin
      return 16'hFFFF;
    end
    if (s < 0) begin
      return 16'h0000;
    end
    q = udiv64((unsigned'(s) << 10) + (unsigned'(c) >> 1), unsigned'(c));
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic tan_rom_t build_tan_rom();
    tan_rom_t rom;
    for (int i = 0; i < 256; i++) begin
      rom[i] = tan_q10(i);
    end
    return rom;
  endfunction

  localparam tan_rom_t TAN_ROM = build_tan_rom();

endpackage

// ===== hdl/sos_arith.sv =====
module sos_arith (
  input  logic                clk,
  input  logic                rst,
  input  sos_pkg::arith_ctl_t ctl,
  input  logic [23:0]         dividend,
  input  logic [7:0]          divisor,
  input  logic [7:0]          span,
  output sos_pkg::arith_sts_t sts,
  output logic [15:0]         mean,
  output logic [15:0]         width
);
  import sos_pkg::*;

  localparam int DIV_STEPS = 24;
  localparam int MUL_STEPS = 16;

  typedef enum logic [3:0] {
    AR_IDLE = 4'b0001,
    AR_DIV  = 4'b0010,
    AR_MUL  = 4'b0100,
    AR_HOLD = 4'b1000
  } arith_state_t;

  arith_state_t state;
  logic [4:0]   cnt;
  logic [23:0]  quo;
  logic [7:0]   rem;
  logic [7:0]   dvs;
  logic [15:0]  tan_q;
  logic [15:0]  mcand;
  logic [31:0]  prod;

  logic [8:0]   shifted;
  logic         fits;
  logic [7:0]   rem_next;
  logic [23:0]  quo_next;
  logic [16:0]  upper_sum;
  logic [31:0]  prod_next;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    shifted  = {rem, quo[23]};
    fits     = shifted >= {1'b0, dvs};
    rem_next = fits ? 8'(shifted - {1'b0, dvs}) : shifted[7:0];
    quo_next = {quo[22:0], fits};
  end

  // shift-add multiply, multiplier bits consumed LSB first
  always_comb begin
    upper_sum = prod[0] ? ({1'b0, prod[31:16]} + {1'b0, mcand}) : {1'b0, prod[31:16]};
    prod_next = {upper_sum, prod[15:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AR_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        AR_IDLE: begin
          if (ctl.start) begin
            quo   <= dividend;
            rem   <= '0;
            dvs   <= divisor;
            tan_q <= TAN_ROM[span];
            cnt   <= 5'(DIV_STEPS - 1);
            state <= AR_DIV;
          end
        end
        AR_DIV: begin
          quo <= quo_next;
          rem <= rem_next;
          if (cnt == '0) begin
            mcand <= (dvs == '0) ? 16'h0000 : quo_next[15:0];
            prod  <= {16'h0000, tan_q};
            cnt   <= 5'(MUL_STEPS - 1);
            state <= AR_MUL;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        AR_MUL: begin
          prod <= prod_next;
          if (cnt == '0) begin
            state <= AR_HOLD;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        AR_HOLD: begin
          if (ctl.take) begin
            state <= AR_IDLE;
          end
        end
        default: state <= AR_IDLE;
      endcase
    end
  end

  // product is mean * tan; width = (2 * product) >> 10
  assign mean     = mcand;
  assign width    = (|prod[31:25]) ? 16'hFFFF : prod[24:9];
  assign sts.busy = (state != AR_IDLE);
  assign sts.done = (state == AR_HOLD);

endmodule

// ===== hdl/sweep_object_segmenter.sv =====
// A sample that ends an object gives its word after the arithmetic unit's 24 divide steps and
// 16 multiply steps, through its hold state and then the output register.
// Throughput: one sample per cycle while no object ends; a sample that ends an object holds off
// the input until its word moves into the output register, which waits while a stalled word still sits there.
// Reset (rst, synchronous): clears the run state, object count and output valid,
// and loads near_limit = 1600, angle_step = 2.
module sweep_object_segmenter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        sweep_start,
  input  logic [7:0]  angle_deg,
  input  logic [15:0] ir_range,
  input  logic [15:0] sonar_range,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  object_number,
  output logic [7:0]  center_angle,
  output logic [15:0] mean_distance,
  output logic [15:0] object_width,
  output logic        count_overflow
);
  import sos_pkg::*;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_FIRST    = 7'b0000010,
    PH_SECOND   = 7'b0000100,
    PH_COUNTED  = 7'b0001000,
    PH_REJECTED = 7'b0010000,
    PH_STILL    = 7'b0100000,
    PH_ENDED    = 7'b1000000
  } phase_t;

  logic [15:0] near_limit;
  logic [3:0]  angle_step;

  phase_t      phase;
  logic [7:0]  run_start_angle;
  logic [23:0] range_sum;
  logic [7:0]  run_samples;
  logic [7:0]  objects_seen;

  phase_t      phase_next;
  logic [7:0]  run_start_angle_next;
  logic [23:0] range_sum_next;
  logic [7:0]  run_samples_next;
  logic [7:0]  objects_seen_next;
  logic        report;

  phase_t      eff_phase;
  logic [7:0]  eff_start;
  logic [23:0] eff_sum;
  logic [7:0]  eff_samples;
  logic [7:0]  eff_objects;

  logic [7:0]  angle_c;
  logic        near;
  logic        far;
  logic        can_acc;
  logic [23:0] acc_sum;
  logic [7:0]  acc_samples;
  logic [7:0]  end_angle;
  logic [7:0]  span;
  logic [8:0]  center_sum;

  logic [7:0]  rep_number;
  logic [7:0]  rep_center;
  logic        rep_overflow;
  logic [23:0] div_dividend;
  logic [7:0]  div_divisor;
  logic [7:0]  div_span;

  logic        in_accept;
  arith_ctl_t  actl;
  arith_sts_t  asts;
  logic [15:0] ar_mean;
  logic [15:0] ar_width;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = asts.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_limit <= 16'd1600;
      angle_step <= 4'd2;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NEAR_LIMIT: near_limit <= cfg_data;
        REG_ANGLE_STEP: angle_step <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_phase   = sweep_start ? PH_IDLE : phase;
    eff_start   = sweep_start ? 8'd0 : run_start_angle;
    eff_sum     = sweep_start ? 24'd0 : range_sum;
    eff_samples = sweep_start ? 8'd0 : run_samples;
    eff_objects = sweep_start ? 8'd0 : objects_seen;

    angle_c = (angle_deg > 8'(ANGLE_MAX)) ? 8'(ANGLE_MAX) : angle_deg;
    near = (sonar_range < near_limit) && (ir_range < near_limit);
    far  = (sonar_range > near_limit) || (ir_range > near_limit);

    can_acc     = (eff_samples != 8'hFF);
    acc_sum     = can_acc ? (eff_sum + 24'(sonar_range)) : eff_sum;
    acc_samples = can_acc ? (eff_samples + 8'd1) : eff_samples;

    end_angle  = (angle_c >= 8'(angle_step)) ? (angle_c - 8'(angle_step)) : 8'd0;
    span       = (end_angle >= eff_start) ? (end_angle - eff_start) : 8'd0;
    center_sum = {1'b0, end_angle} + {1'b0, eff_start};

    phase_next           = eff_phase;
    run_start_angle_next = eff_start;
    range_sum_next       = eff_sum;
    run_samples_next     = eff_samples;
    objects_seen_next    = eff_objects;
    report               = 1'b0;

    if (near && (eff_phase == PH_IDLE || eff_phase == PH_REJECTED || eff_phase == PH_ENDED)) begin
      phase_next           = PH_FIRST;
      run_start_angle_next = angle_c;
      range_sum_next       = 24'(sonar_range);
      run_samples_next     = 8'd1;
    end else if (near && eff_phase == PH_FIRST) begin
      phase_next       = PH_SECOND;
      range_sum_next   = acc_sum;
      run_samples_next = acc_samples;
    end else if (near && eff_phase == PH_SECOND) begin
      phase_next        = PH_COUNTED;
      range_sum_next    = acc_sum;
      run_samples_next  = acc_samples;
      objects_seen_next = (eff_objects != 8'hFF) ? (eff_objects + 8'd1) : eff_objects;
    end else if (far && (eff_phase == PH_FIRST || eff_phase == PH_SECOND)) begin
      phase_next       = (eff_objects == 8'd0) ? PH_IDLE : PH_REJECTED;
      range_sum_next   = '0;
      run_samples_next = '0;
    end else if (near && (eff_phase == PH_COUNTED || eff_phase == PH_STILL)) begin
      phase_next       = PH_STILL;
      range_sum_next   = acc_sum;
      run_samples_next = acc_samples;
    end else if (far && (eff_phase == PH_COUNTED || eff_phase == PH_STILL)) begin
      phase_next       = PH_ENDED;
      range_sum_next   = '0;
      run_samples_next = '0;
      report           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      run_start_angle <= '0;
      range_sum       <= '0;
      run_samples     <= '0;
      objects_seen    <= '0;
    end else if (in_accept) begin
      phase           <= phase_next;
      run_start_angle <= run_start_angle_next;
      range_sum       <= range_sum_next;
      run_samples     <= run_samples_next;
      objects_seen    <= objects_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && report) begin
      rep_number   <= eff_objects;
      rep_center   <= center_sum[8:1];
      rep_overflow <= (eff_objects > 8'(MAX_OBJECTS));
    end
  end

  assign div_dividend = eff_sum;
  assign div_divisor  = eff_samples;
  assign div_span     = span;
  assign actl.start   = in_accept && report;
  assign actl.take    = !out_valid || !out_stall;

  sos_arith u_arith (
    .clk      (clk),
    .rst      (rst),
    .ctl      (actl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .span     (div_span),
    .sts      (asts),
    .mean     (ar_mean),
    .width    (ar_width)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (asts.done && actl.take) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (asts.done && actl.take) begin
      object_number  <= rep_number;
      center_angle   <= rep_center;
      mean_distance  <= ar_mean;
      object_width   <= ar_width;
      count_overflow <= rep_overflow;
    end
  end

endmodule

// ===== hdl/sos_checker.sv =====
module sos_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] object_number,
  input logic [7:0] center_angle,
  input logic       count_overflow
);
  import sos_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_word_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled word dropped");

  a_overflow_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count_overflow == (object_number > 8'(MAX_OBJECTS))))
    else $error("count_overflow disagrees with object_number");

  a_word_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (object_number != 8'd0) && (center_angle <= 8'(ANGLE_MAX)))
    else $error("object word out of range");

  a_word_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("object word without a busy period");

endmodule

bind sweep_object_segmenter sos_checker u_sos_checker (.*);
